/* sv/ekm_pkg.sv */
package ekm_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int SUM_W = 16;
	localparam logic [7:0] EDGE_MAX = 8'd255;
	localparam logic [7:0] EDGE_MIN = 8'd0;
	localparam logic [32:0] SAT_SQ = 33'd65025;

	typedef struct packed {
		logic [SUM_W-1:0] sum_x;
		logic [SUM_W-1:0] sum_y;
		logic             lap_mode;
	} ekm_win_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQUARE,
		BK_SUM,
		BK_ROOT,
		BK_DONE
	} ekm_bk_state_t;

endpackage

/* sv/edge_kernel_magnitude_unit.sv */
// Accepts one window element per cycle while the two-entry window queue has room.
// After the last element is accepted the window passes the queue to the back end: IDLE, then
// DONE in Laplacian mode, else SQUARE and SUM, then DONE when the square sum saturates, or
// ROOT (one root bit per cycle) before DONE. The back end takes one window at a time;
// the accumulator waits on it only when the window queue is full.
// arst_n clears the sums, the queue, the output valid and laplacian_mode.
module edge_kernel_magnitude_unit import ekm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        pixel,
	input  logic signed [7:0] coef_x,
	input  logic signed [7:0] coef_y,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        edge_value
);

	logic     lap_mode_q;
	logic     push;
	ekm_win_t push_win;
	logic     pop;
	ekm_win_t pop_win;
	logic     q_full;
	logic     q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lap_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			lap_mode_q <= cfg_data;
		end
	end

	ekm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel    (pixel),
		.coef_x   (coef_x),
		.coef_y   (coef_y),
		.last     (last),
		.lap_mode (lap_mode_q),
		.q_full   (q_full),
		.push     (push),
		.push_win (push_win)
	);

	ekm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_win (push_win),
		.pop      (pop),
		.pop_win  (pop_win),
		.full     (q_full),
		.empty    (q_empty)
	);

	ekm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_win      (pop_win),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_value (edge_value)
	);

endmodule

/* sv/ekm_front.sv */
module ekm_front import ekm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        pixel,
	input  logic signed [7:0] coef_x,
	input  logic signed [7:0] coef_y,
	input  logic              last,
	input  logic              lap_mode,
	input  logic              q_full,
	output logic              push,
	output ekm_win_t          push_win
);

	logic [SUM_W-1:0]  sum_x_q;
	logic [SUM_W-1:0]  sum_y_q;
	logic signed [16:0] prod_x;
	logic signed [16:0] prod_y;
	logic [SUM_W-1:0]  sum_x_nx;
	logic [SUM_W-1:0]  sum_y_nx;
	logic              accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign prod_x = $signed({1'b0, pixel}) * coef_x;
	assign prod_y = $signed({1'b0, pixel}) * coef_y;

	// wrap modulo 2^16
	assign sum_x_nx = sum_x_q + prod_x[SUM_W-1:0];
	assign sum_y_nx = sum_y_q + prod_y[SUM_W-1:0];

	assign push              = accept && last;
	assign push_win.sum_x    = sum_x_nx;
	assign push_win.sum_y    = sum_y_nx;
	assign push_win.lap_mode = lap_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (accept) begin
			if (last) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
			end else begin
				sum_x_q <= sum_x_nx;
				sum_y_q <= sum_y_nx;
			end
		end
	end

endmodule

/* sv/ekm_queue.sv */
module ekm_queue import ekm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ekm_win_t push_win,
	input  logic     pop,
	output ekm_win_t pop_win,
	output logic     full,
	output logic     empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	ekm_win_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_win = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* sv/ekm_back.sv */
module ekm_back import ekm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  ekm_win_t   q_win,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] edge_value
);

	ekm_bk_state_t    state_q;
	ekm_bk_state_t    state_nx;
	logic [15:0]      ax_q;
	logic [15:0]      ay_q;
	logic [31:0]      sqx_q;
	logic [31:0]      sqy_q;
	logic [15:0]      rad_q;
	logic [7:0]       root_q;
	logic [7:0]       res_q;
	logic [2:0]       step_q;
	logic             out_valid_q;
	logic [7:0]       edge_q;
	logic             load_out;
	logic [15:0]      abs_x;
	logic [15:0]      abs_y;
	logic [7:0]       lap_res;
	logic [32:0]      sq_sum;
	logic [7:0]       trial;
	logic [15:0]      trial_sq;
	logic [7:0]       root_nx;

	assign abs_x = q_win.sum_x[15] ? (16'd0 - q_win.sum_x) : q_win.sum_x;
	assign abs_y = q_win.sum_y[15] ? (16'd0 - q_win.sum_y) : q_win.sum_y;

	always_comb begin
		if (q_win.sum_x[15]) begin
			lap_res = EDGE_MIN;
		end else if (q_win.sum_x[14:8] != '0) begin
			lap_res = EDGE_MAX;
		end else begin
			lap_res = q_win.sum_x[7:0];
		end
	end

	assign sq_sum   = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign trial    = root_q | (8'd1 << step_q);
	assign trial_sq = trial * trial;
	assign root_nx  = (trial_sq <= rad_q) ? trial : root_q;

	always_comb begin
		state_nx = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop      = 1'b1;
					state_nx = q_win.lap_mode ? BK_DONE : BK_SQUARE;
				end
			end
			BK_SQUARE: begin
				state_nx = BK_SUM;
			end
			BK_SUM: begin
				state_nx = (sq_sum >= SAT_SQ) ? BK_DONE : BK_ROOT;
			end
			BK_ROOT: begin
				if (step_q == '0) begin
					state_nx = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_nx = BK_IDLE;
				end
			end
			default: begin
				state_nx = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == BK_SUM) begin
				step_q <= 3'd7;
			end else if (state_q == BK_ROOT) begin
				step_q <= step_q - 3'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				ax_q  <= abs_x;
				ay_q  <= abs_y;
				res_q <= lap_res;
			end
			BK_SQUARE: begin
				sqx_q <= ax_q * ax_q;
				sqy_q <= ay_q * ay_q;
			end
			BK_SUM: begin
				// below the saturation bound the sum fits in 16 bits
				rad_q  <= sq_sum[15:0];
				root_q <= '0;
				res_q  <= EDGE_MAX;
			end
			BK_ROOT: begin
				root_q <= root_nx;
				res_q  <= root_nx;
			end
			BK_DONE: begin
				if (load_out) begin
					edge_q <= res_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign edge_value = edge_q;

endmodule

/* tb/ekm_result_checker.sv */
`timescale 1ns / 100ps

module ekm_result_checker import ekm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        pixel,
	input  logic signed [7:0] coef_x,
	input  logic signed [7:0] coef_y,
	input  logic              last,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        edge_value,
	output int                fail_count,
	output int                pending,
	output int                results_checked
);

	logic [SUM_W-1:0] acc_x;
	logic [SUM_W-1:0] acc_y;
	logic             lap_mode;
	logic [7:0]       edge_expected[$];
	int               errors;
	int               checked;

	// floor root of the gradient, or the clamped x sum in Laplacian mode
	function automatic logic [7:0] window_edge(logic [SUM_W-1:0] sx, logic [SUM_W-1:0] sy,
			logic lap);
		logic signed [SUM_W-1:0] gx;
		logic [SUM_W-1:0]        mag_x;
		logic [SUM_W-1:0]        mag_y;
		logic [32:0]             sq;
		logic [7:0]              root;
		logic [7:0]              trial;
		gx = sx;
		if (lap) begin
			if (gx < 0)
				return EDGE_MIN;
			if (gx > 255)
				return EDGE_MAX;
			return sx[7:0];
		end
		mag_x = sx[SUM_W-1] ? (~sx + 1'b1) : sx;
		mag_y = sy[SUM_W-1] ? (~sy + 1'b1) : sy;
		sq = 33'(mag_x) * 33'(mag_x) + 33'(mag_y) * 33'(mag_y);
		if (sq >= SAT_SQ)
			return EDGE_MAX;
		root = 8'd0;
		for (int b = 7; b >= 0; b--) begin
			trial = root | (8'd1 << b);
			if (33'(trial) * 33'(trial) <= sq)
				root = trial;
		end
		return root;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic signed [SUM_W-1:0] prod_x;
		logic signed [SUM_W-1:0] prod_y;
		logic [SUM_W-1:0]        next_x;
		logic [SUM_W-1:0]        next_y;
		logic [7:0]              want;
		if (!arst_n) begin
			acc_x <= '0;
			acc_y <= '0;
			lap_mode <= 1'b0;
			edge_expected.delete();
			errors = 0;
			checked = 0;
			fail_count <= 0;
			pending <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				lap_mode <= cfg_data;
			if (in_valid && in_ready) begin
				prod_x = $signed({1'b0, pixel}) * coef_x;
				prod_y = $signed({1'b0, pixel}) * coef_y;
				next_x = acc_x + prod_x;
				next_y = acc_y + prod_y;
				if (last) begin
					edge_expected.push_back(window_edge(next_x, next_y, lap_mode));
					acc_x <= '0;
					acc_y <= '0;
				end else begin
					acc_x <= next_x;
					acc_y <= next_y;
				end
			end
			if (out_valid && out_ready) begin
				if (edge_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected edge_value %0d, expected none", $time,
						edge_value);
				end else begin
					want = edge_expected.pop_front();
					checked++;
					if (edge_value !== want) begin
						errors++;
						$display("%0t: edge_value mismatch, expected %0d, actual %0d",
							$time, want, edge_value);
					end
				end
			end
			fail_count <= errors;
			pending <= edge_expected.size();
			results_checked <= checked;
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

	localparam int SEG_ITEMS = 215;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_data = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        pixel = '0;
	logic signed [7:0] coef_x = '0;
	logic signed [7:0] coef_y = '0;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        edge_value;

	int fail_count;
	int pending;
	int results_checked;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	int items_sent = 0;
	int windows_sent = 0;
	int mode_writes = 0;

	always #6 clk = ~clk;

	edge_kernel_magnitude_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.coef_x     (coef_x),
		.coef_y     (coef_y),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_value (edge_value)
	);

	ekm_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pixel           (pixel),
		.coef_x          (coef_x),
		.coef_y          (coef_y),
		.last            (last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.edge_value      (edge_value),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// output side: a requested hold-off wins over the random stall pattern
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("edge_kernel_magnitude_unit regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_element(input logic [7:0] p, input logic signed [7:0] cx,
			input logic signed [7:0] cy, input logic is_last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		coef_x <= cx;
		coef_y <= cy;
		last <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (is_last)
			windows_sent++;
	endtask

	// drop valid and wait until every expected edge_value has drained
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic lap);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= lap;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_writes++;
	endtask

	task automatic send_random_window(input int taps);
		int                style;
		logic [7:0]        p;
		logic signed [7:0] cx;
		logic signed [7:0] cy;
		style = $urandom_range(0, 9);
		for (int i = 0; i < taps; i++) begin
			case ($urandom_range(0, 9))
				0:       p = 8'd0;
				1:       p = 8'd255;
				default: p = 8'($urandom_range(0, 255));
			endcase
			if (style >= 8)
				p = 8'($urandom_range(0, 15));
			if (style <= 3) begin
				// kernel-like coefficients between -10 and 10
				cx = $signed(8'($urandom_range(0, 20))) - 8'sd10;
				cy = $signed(8'($urandom_range(0, 20))) - 8'sd10;
			end else if (style == 7) begin
				cx = $urandom_range(0, 1) ? 8'sd0 : $signed(8'($urandom_range(0, 255)));
				cy = $urandom_range(0, 1) ? 8'sd0 : $signed(8'($urandom_range(0, 255)));
			end else begin
				cx = $signed(8'($urandom_range(0, 255)));
				cy = $signed(8'($urandom_range(0, 255)));
			end
			send_element(p, cx, cy, i == taps - 1);
		end
	endtask

	function automatic int pick_window_taps();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 25;
		if (r < 15)
			return $urandom_range(26, 60);
		if (r < 25)
			return 9;
		return $urandom_range(1, 8);
	endfunction

	initial begin
		int seg_start;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gradient mode from reset: zero, saturation, wrap, exact and near-limit roots
		send_element(8'd0, 8'sd0, 8'sd0, 1'b1);
		send_element(8'd255, 8'sd127, -8'sd128, 1'b1);
		send_element(8'd255, -8'sd128, 8'sd0, 1'b0);
		send_element(8'd255, -8'sd128, 8'sd0, 1'b0);
		send_element(8'd200, -8'sd1, 8'sd0, 1'b1);
		send_element(8'd1, 8'sd3, 8'sd4, 1'b1);
		send_element(8'd1, 8'sd1, 8'sd1, 1'b1);
		send_element(8'd180, 8'sd1, 8'sd1, 1'b1);
		send_element(8'd254, 8'sd1, 8'sd0, 1'b1);
		send_element(8'd255, 8'sd1, 8'sd0, 1'b1);
		send_element(8'd128, -8'sd128, -8'sd128, 1'b1);
		// switch to Laplacian in the middle of a window
		send_element(8'd100, 8'sd2, 8'sd3, 1'b0);
		write_mode(1'b1);
		send_element(8'd10, 8'sd1, -8'sd7, 1'b1);
		send_element(8'd10, -8'sd5, 8'sd9, 1'b1);
		send_element(8'd150, 8'sd2, 8'sd0, 1'b1);
		send_element(8'd255, 8'sd1, 8'sd0, 1'b1);
		send_element(8'd0, 8'sd0, 8'sd0, 1'b1);
		// back to gradient mid-window; sum_y from the Laplacian part must carry over
		send_element(8'd50, 8'sd1, 8'sd2, 1'b0);
		write_mode(1'b0);
		send_element(8'd30, 8'sd1, 8'sd2, 1'b1);

		for (int seg = 0; seg < 6; seg++) begin
			write_mode(logic'(seg % 2));
			case (seg / 2)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct <= 70;
				end
				1: begin
					tx_idle_pct = 70;
					rx_idle_pct <= 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			seg_start = items_sent;
			if (seg == 4) begin
				// long output stall while short windows keep coming: input must back up
				hold_reqs <= hold_reqs + 1;
				repeat (40) send_random_window($urandom_range(1, 3));
			end
			while (items_sent - seg_start < SEG_ITEMS)
				send_random_window(pick_window_taps());
		end

		drain_results();
		$display("covered %0d items in %0d windows, %0d edge values checked", items_sent,
			windows_sent, results_checked);
		$display("both modes over %0d mode writes, three stall mixes and a long output hold",
			mode_writes);
		if (fail_count == 0 && pending == 0)
			$display("edge_kernel_magnitude_unit regression: pass");
		else
			$display("edge_kernel_magnitude_unit regression: fail");
		$finish;
	end

endmodule
